// ----- sv/rgbfb_pkg.sv -----
// Shared types, constants and blend arithmetic for the RGB565 draw engine.
// No dependencies; used by rgbfb_pix_unit and the top level.
package rgbfb_pkg;

	// coordinate, input field, dimension, visit count and pixel widths
	localparam int IW   = 12;
	localparam int CW   = 14;
	localparam int DIMW = 11;
	localparam int VW   = 20;
	localparam int PW   = 16;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

	typedef logic signed [CW-1:0] coord_t;

	localparam coord_t COORD_ONE = 1;

	typedef enum logic [2:0] {
		REQ_PIXEL  = 3'd0,
		REQ_BLEND  = 3'd1,
		REQ_SPAN   = 3'd2,
		REQ_LINE   = 3'd3,
		REQ_RECT   = 3'd4,
		REQ_FILL   = 3'd5,
		REQ_CIRCLE = 3'd6,
		REQ_READ   = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		PIX_WRITE = 2'd0,
		PIX_BLEND = 2'd1,
		PIX_READ  = 2'd2
	} pix_op_t;

	typedef struct packed {
		logic            valid;
		pix_op_t         op;
		coord_t          x;
		coord_t          y;
		logic [PW-1:0]   color;
		logic [7:0]      alpha;
	} pix_req_t;

	typedef struct packed {
		logic            ready;
		logic            done;
		logic            hit;
		logic [PW-1:0]   rdata;
	} pix_rsp_t;

	// sign-extend a 12-bit input field to coordinate width
	function automatic coord_t sext_in(input logic [IW-1:0] v);
		return {{(CW-IW){v[IW-1]}}, v};
	endfunction

	// floor(v/255) for v below 65280
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = 17'(v) + 17'(v[15:8]) + 17'd1;
		return t[15:8];
	endfunction

	// per channel (src*a + dst*(255-a))/255, truncated
	function automatic logic [PW-1:0] blend565(input logic [PW-1:0] src,
		input logic [PW-1:0] dst, input logic [7:0] a);
		logic [7:0]  na;
		logic [15:0] sr, sg, sb;
		logic [7:0]  qr, qg, qb;
		na = ALPHA_OPAQUE - a;
		sr = 16'(src[15:11] * a) + 16'(dst[15:11] * na);
		sg = 16'(src[10:5] * a) + 16'(dst[10:5] * na);
		sb = 16'(src[4:0] * a) + 16'(dst[4:0] * na);
		qr = div255(sr);
		qg = div255(sg);
		qb = div255(sb);
		return {qr[4:0], qg[5:0], qb[4:0]};
	endfunction

endpackage

// ----- sv/rgbfb_pix_unit.sv -----
// Pixel access unit: frame store memory, clearing pass, clipping, address and blend.
// Depends on rgbfb_pkg.
module rgbfb_pix_unit import rgbfb_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [DIMW-1:0] eff_w,
	input  logic [DIMW-1:0] eff_h,
	input  pix_req_t        req,
	output pix_rsp_t        rsp
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int MW    = YW + DIMW;

	typedef enum logic [3:0] {
		PU_CLEAR = 4'b0001,
		PU_IDLE  = 4'b0010,
		PU_ACC   = 4'b0100,
		PU_MIX   = 4'b1000
	} pu_state_t;

	pu_state_t     state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] addr_q;
	logic          hit_q;
	pix_op_t       op_q;
	logic [PW-1:0] color_q;
	logic [7:0]    alpha_q;
	logic [PW-1:0] rd_q;

	logic [PW-1:0] mem [DEPTH];

	logic          in_canvas;
	logic [MW-1:0] lin_addr;
	logic          we, re;
	logic [AW-1:0] maddr;
	logic [PW-1:0] wdata;
	logic          done;
	logic          alpha_mid;

	// clip against the canvas and form y*W+x
	assign in_canvas = (req.x >= 0) && (req.x < $signed(CW'(eff_w)))
		&& (req.y >= 0) && (req.y < $signed(CW'(eff_h)));
	assign lin_addr = MW'(req.y[YW-1:0] * eff_w) + MW'(req.x[XW-1:0]);
	assign alpha_mid = (alpha_q != ALPHA_OPAQUE) && (alpha_q != ALPHA_CLEAR);

	// decode memory access for the current state
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		done  = 1'b0;
		maddr = addr_q;
		wdata = color_q;
		unique case (state_q)
			PU_CLEAR: begin
				we    = 1'b1;
				maddr = clr_q;
				wdata = '0;
			end
			PU_IDLE: ;
			PU_ACC: begin
				case (op_q)
					PIX_WRITE: begin
						we   = hit_q;
						done = 1'b1;
					end
					PIX_BLEND: begin
						we   = hit_q && (alpha_q == ALPHA_OPAQUE);
						re   = hit_q && alpha_mid;
						done = !re;
					end
					PIX_READ: begin
						re   = hit_q;
						done = !hit_q;
					end
					default: done = 1'b1;
				endcase
			end
			PU_MIX: begin
				done  = 1'b1;
				we    = (op_q == PIX_BLEND);
				wdata = blend565(color_q, rd_q, alpha_q);
			end
			default: ;
		endcase
	end

	// frame store, one port, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[maddr] <= wdata;
		if (re)
			rd_q <= mem[maddr];
	end

	// sequence clearing pass and pixel accesses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PU_CLEAR;
			clr_q   <= '0;
			addr_q  <= '0;
			hit_q   <= 1'b0;
			op_q    <= PIX_WRITE;
			color_q <= '0;
			alpha_q <= '0;
		end else begin
			unique case (state_q)
				PU_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1))
						state_q <= PU_IDLE;
				end
				PU_IDLE: begin
					if (req.valid) begin
						op_q    <= req.op;
						color_q <= req.color;
						alpha_q <= req.alpha;
						hit_q   <= in_canvas;
						addr_q  <= lin_addr[AW-1:0];
						state_q <= PU_ACC;
					end
				end
				PU_ACC: state_q <= re ? PU_MIX : PU_IDLE;
				PU_MIX: state_q <= PU_IDLE;
				default: state_q <= PU_IDLE;
			endcase
		end
	end

	assign rsp.ready = (state_q == PU_IDLE);
	assign rsp.done  = done;
	assign rsp.hit   = hit_q;
	assign rsp.rdata = rd_q;

	// no pixel request may arrive while the store is being cleared
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PU_CLEAR) |-> !req.valid) else $error("request during clear");
	// every completed access leaves the unit ready for the next pixel
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == PU_IDLE)) else $error("unit not idle after done");
	// the merge cycle always follows a read issued in the access cycle
	a_mix_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PU_MIX) |-> $past(re)) else $error("merge without read");

endmodule

// ----- sv/rgb565_framebuffer_draw_engine.sv -----
// Top level of the RGB565 draw engine: stream ports, canvas registers, command sequencer.
// Depends on rgbfb_pkg and rgbfb_pix_unit.
//
// After reset the frame store is cleared one word a cycle, all MAX_WIDTH*MAX_HEIGHT words
// (65536 at the defaults); no command is accepted until that pass ends, canvas writes are
// taken throughout. Commands run one at a time and give one result item each. Pixel
// positions are visited one at a time through the single port of the frame store; a
// read, or a blend with alpha strictly between clear and opaque, of an on-canvas pixel
// adds a merge step after its read. A rectangle outline is drawn as four segments, each
// with its own set-up. The next command is accepted while the previous result still
// waits in the output register.
module rgb565_framebuffer_draw_engine import rgbfb_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [8:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// x_a[11:0], y_a[23:12], x_b[35:24], y_b[47:36], color[63:48], alpha[71:64]
	input  logic [71:0] s_axis_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[15:0], pixels_visited[35:16], zero[39:36]
	output logic [39:0] m_axis_tdata
);

	localparam logic [0:0] CFG_WIDTH  = 1'b0;
	localparam logic [0:0] CFG_HEIGHT = 1'b1;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SETUP = 6'b000010,
		S_LINIT = 6'b000100,
		S_EMIT  = 6'b001000,
		S_WAIT  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		M_ONE  = 2'd0,
		M_RAST = 2'd1,
		M_LINE = 2'd2,
		M_CIRC = 2'd3
	} mode_t;

	state_t            state_q;
	mode_t             mode_q;
	req_t              req_q;
	pix_op_t           op_q;
	logic [8:0]        cw_q, ch_q;
	logic [IW-1:0]     xa_q, ya_q, xb_q, yb_q;
	logic [PW-1:0]     color_q;
	logic [7:0]        alpha_q;
	coord_t            px_q, py_q;
	coord_t            rxs_q, rxe_q, rye_q;
	coord_t            x0_q, y0_q, x1_q, y1_q;
	logic [1:0]        seg_q;
	logic              is_line_q;
	coord_t            lex_q, ley_q, dx_q, dy_q;
	logic              sxn_q, syn_q;
	logic signed [15:0] err_q;
	coord_t            cx_q, cy_q, cxr_q, cyr_q;
	logic signed [17:0] cerr_q;
	logic [2:0]        oct_q;
	logic [VW-1:0]     visits_q;
	logic [PW-1:0]     rd_res_q;
	logic              out_valid_q;
	logic [PW-1:0]     out_rd_q;
	logic [VW-1:0]     out_vis_q;

	logic [DIMW-1:0]   eff_w, eff_h;
	coord_t            effw_s, effh_s;
	coord_t            xa_s, ya_s, xb_s, yb_s;
	pix_req_t          pix_req;
	pix_rsp_t          pix_rsp;
	logic              in_acc;
	logic              out_free;

	// clamp canvas size to 1..MAX
	always_comb begin
		if (cw_q == '0)
			eff_w = DIMW'(1);
		else if (DIMW'(cw_q) > DIMW'(MAX_WIDTH))
			eff_w = DIMW'(MAX_WIDTH);
		else
			eff_w = DIMW'(cw_q);
		if (ch_q == '0)
			eff_h = DIMW'(1);
		else if (DIMW'(ch_q) > DIMW'(MAX_HEIGHT))
			eff_h = DIMW'(MAX_HEIGHT);
		else
			eff_h = DIMW'(ch_q);
	end

	assign effw_s = $signed(CW'(eff_w));
	assign effh_s = $signed(CW'(eff_h));
	assign xa_s   = sext_in(xa_q);
	assign ya_s   = sext_in(ya_q);
	assign xb_s   = sext_in(xb_q);
	assign yb_s   = sext_in(yb_q);

	// span: order ends and clamp to the canvas
	coord_t sp_lo, sp_hi, sp_x0, sp_x1;
	logic   sp_empty;
	always_comb begin
		sp_lo    = (xa_s > xb_s) ? xb_s : xa_s;
		sp_hi    = (xa_s > xb_s) ? xa_s : xb_s;
		sp_x0    = (sp_lo < 0) ? '0 : sp_lo;
		sp_x1    = (sp_hi >= effw_s) ? effw_s - COORD_ONE : sp_hi;
		sp_empty = (ya_s < 0) || (ya_s >= effh_s) || (sp_x0 > sp_x1);
	end

	// filled rectangle: clip origin and extent to the canvas
	coord_t fx, fy, fw0, fh0, fw, fh;
	logic   fl_empty;
	always_comb begin
		fx       = (xa_s < 0) ? '0 : xa_s;
		fw0      = (xa_s < 0) ? xb_s + xa_s : xb_s;
		fy       = (ya_s < 0) ? '0 : ya_s;
		fh0      = (ya_s < 0) ? yb_s + ya_s : yb_s;
		fw       = (fx + fw0 > effw_s) ? effw_s - fx : fw0;
		fh       = (fy + fh0 > effh_s) ? effh_s - fy : fh0;
		fl_empty = (fw <= 0) || (fh <= 0);
	end

	// segment endpoints for line and rectangle outline
	coord_t ls_x, ls_y, le_x, le_y, l_dx, l_dy;
	always_comb begin
		ls_x = x0_q;
		ls_y = y0_q;
		le_x = x1_q;
		le_y = y1_q;
		if (!is_line_q) begin
			case (seg_q)
				2'd0: le_y = y0_q;
				2'd1: ls_y = y1_q;
				2'd2: le_x = x0_q;
				default: ls_x = x1_q;
			endcase
		end
		l_dx = (le_x >= ls_x) ? le_x - ls_x : ls_x - le_x;
		l_dy = (le_y >= ls_y) ? ls_y - le_y : le_y - ls_y;
	end

	// Bresenham step
	logic signed [16:0] e2;
	logic               step_x, step_y;
	coord_t             ln_x, ln_y;
	logic signed [15:0] ln_err;
	always_comb begin
		e2     = {err_q, 1'b0};
		step_x = (e2 >= 17'(dy_q));
		step_y = (e2 <= 17'(dx_q));
		ln_x   = px_q;
		ln_y   = py_q;
		ln_err = err_q;
		if (step_x) begin
			ln_err = ln_err + 16'(dy_q);
			ln_x   = sxn_q ? px_q - COORD_ONE : px_q + COORD_ONE;
		end
		if (step_y) begin
			ln_err = ln_err + 16'(dx_q);
			ln_y   = syn_q ? py_q - COORD_ONE : py_q + COORD_ONE;
		end
	end

	// midpoint circle: octant point and step
	coord_t             cp_x, cp_y;
	coord_t             cn_x, cn_y;
	logic signed [17:0] c_err1, c_err2, c_test;
	always_comb begin
		case (oct_q)
			3'd0: begin cp_x = cx_q + cxr_q; cp_y = cy_q + cyr_q; end
			3'd1: begin cp_x = cx_q + cyr_q; cp_y = cy_q + cxr_q; end
			3'd2: begin cp_x = cx_q - cyr_q; cp_y = cy_q + cxr_q; end
			3'd3: begin cp_x = cx_q - cxr_q; cp_y = cy_q + cyr_q; end
			3'd4: begin cp_x = cx_q - cxr_q; cp_y = cy_q - cyr_q; end
			3'd5: begin cp_x = cx_q - cyr_q; cp_y = cy_q - cxr_q; end
			3'd6: begin cp_x = cx_q + cyr_q; cp_y = cy_q - cxr_q; end
			default: begin cp_x = cx_q + cxr_q; cp_y = cy_q - cyr_q; end
		endcase
		cn_y   = cyr_q + COORD_ONE;
		c_err1 = cerr_q + 18'sd1 + (18'(cn_y) <<< 1);
		c_test = ((c_err1 - 18'(cxr_q)) <<< 1) + 18'sd1;
		cn_x   = cxr_q;
		c_err2 = c_err1;
		if (c_test > 0) begin
			cn_x   = cxr_q - COORD_ONE;
			c_err2 = c_err1 + 18'sd1 - (18'(cn_x) <<< 1);
		end
	end

	// drive the pixel unit
	always_comb begin
		pix_req.valid = (state_q == S_EMIT);
		pix_req.op    = op_q;
		pix_req.x     = (mode_q == M_CIRC) ? cp_x : px_q;
		pix_req.y     = (mode_q == M_CIRC) ? cp_y : py_q;
		pix_req.color = color_q;
		pix_req.alpha = alpha_q;
	end

	rgbfb_pix_unit #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pix (
		.clk    (clk),
		.arst_n (arst_n),
		.eff_w  (eff_w),
		.eff_h  (eff_h),
		.req    (pix_req),
		.rsp    (pix_rsp)
	);

	assign s_axis_tready = (state_q == S_IDLE) && pix_rsp.ready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// canvas registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= 9'd256;
			ch_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  cw_q <= cfg_wdata;
				CFG_HEIGHT: ch_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_ONE;
			req_q       <= REQ_PIXEL;
			op_q        <= PIX_WRITE;
			xa_q        <= '0;
			ya_q        <= '0;
			xb_q        <= '0;
			yb_q        <= '0;
			color_q     <= '0;
			alpha_q     <= '0;
			px_q        <= '0;
			py_q        <= '0;
			rxs_q       <= '0;
			rxe_q       <= '0;
			rye_q       <= '0;
			x0_q        <= '0;
			y0_q        <= '0;
			x1_q        <= '0;
			y1_q        <= '0;
			seg_q       <= '0;
			is_line_q   <= 1'b0;
			lex_q       <= '0;
			ley_q       <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			sxn_q       <= 1'b0;
			syn_q       <= 1'b0;
			err_q       <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			cxr_q       <= '0;
			cyr_q       <= '0;
			cerr_q      <= '0;
			oct_q       <= '0;
			visits_q    <= '0;
			rd_res_q    <= '0;
			out_valid_q <= 1'b0;
			out_rd_q    <= '0;
			out_vis_q   <= '0;
		end else begin
			// release the output register when taken
			if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						req_q    <= req_t'(s_axis_tuser);
						xa_q     <= s_axis_tdata[11:0];
						ya_q     <= s_axis_tdata[23:12];
						xb_q     <= s_axis_tdata[35:24];
						yb_q     <= s_axis_tdata[47:36];
						color_q  <= s_axis_tdata[63:48];
						alpha_q  <= s_axis_tdata[71:64];
						visits_q <= '0;
						rd_res_q <= '0;
						state_q  <= S_SETUP;
					end
				end
				S_SETUP: begin
					unique case (req_q) inside
						REQ_PIXEL, REQ_BLEND, REQ_READ: begin
							mode_q  <= M_ONE;
							op_q    <= (req_q == REQ_PIXEL) ? PIX_WRITE :
								(req_q == REQ_BLEND) ? PIX_BLEND : PIX_READ;
							px_q    <= xa_s;
							py_q    <= ya_s;
							state_q <= S_EMIT;
						end
						REQ_SPAN: begin
							mode_q  <= M_RAST;
							op_q    <= PIX_BLEND;
							px_q    <= sp_x0;
							py_q    <= ya_s;
							rxs_q   <= sp_x0;
							rxe_q   <= sp_x1;
							rye_q   <= ya_s;
							state_q <= sp_empty ? S_DONE : S_EMIT;
						end
						REQ_FILL: begin
							mode_q  <= M_RAST;
							op_q    <= PIX_BLEND;
							px_q    <= fx;
							py_q    <= fy;
							rxs_q   <= fx;
							rxe_q   <= fx + fw - COORD_ONE;
							rye_q   <= fy + fh - COORD_ONE;
							state_q <= fl_empty ? S_DONE : S_EMIT;
						end
						REQ_LINE: begin
							mode_q    <= M_LINE;
							op_q      <= PIX_WRITE;
							is_line_q <= 1'b1;
							x0_q      <= xa_s;
							y0_q      <= ya_s;
							x1_q      <= xb_s;
							y1_q      <= yb_s;
							state_q   <= S_LINIT;
						end
						REQ_RECT: begin
							mode_q    <= M_LINE;
							op_q      <= PIX_WRITE;
							is_line_q <= 1'b0;
							seg_q     <= 2'd0;
							x0_q      <= xa_s;
							y0_q      <= ya_s;
							x1_q      <= xa_s + xb_s - COORD_ONE;
							y1_q      <= ya_s + yb_s - COORD_ONE;
							state_q   <= ((xb_s <= 0) || (yb_s <= 0)) ? S_DONE : S_LINIT;
						end
						REQ_CIRCLE: begin
							mode_q  <= M_CIRC;
							op_q    <= PIX_WRITE;
							cx_q    <= xa_s;
							cy_q    <= ya_s;
							cxr_q   <= xb_s;
							cyr_q   <= '0;
							cerr_q  <= '0;
							oct_q   <= '0;
							state_q <= (xb_s < 0) ? S_DONE : S_EMIT;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_LINIT: begin
					px_q    <= ls_x;
					py_q    <= ls_y;
					lex_q   <= le_x;
					ley_q   <= le_y;
					dx_q    <= l_dx;
					dy_q    <= l_dy;
					sxn_q   <= !(ls_x < le_x);
					syn_q   <= !(ls_y < le_y);
					err_q   <= 16'(l_dx) + 16'(l_dy);
					state_q <= S_EMIT;
				end
				S_EMIT: state_q <= S_WAIT;
				S_WAIT: begin
					if (pix_rsp.done) begin
						if (pix_rsp.hit && (visits_q != '1))
							visits_q <= visits_q + VW'(1);
						if (pix_rsp.hit && (op_q == PIX_READ))
							rd_res_q <= pix_rsp.rdata;
						// advance to the next pixel position
						unique case (mode_q)
							M_ONE: state_q <= S_DONE;
							M_RAST: begin
								if (px_q == rxe_q) begin
									px_q    <= rxs_q;
									py_q    <= py_q + COORD_ONE;
									state_q <= (py_q == rye_q) ? S_DONE : S_EMIT;
								end else begin
									px_q    <= px_q + COORD_ONE;
									state_q <= S_EMIT;
								end
							end
							M_LINE: begin
								if ((px_q == lex_q) && (py_q == ley_q)) begin
									seg_q   <= seg_q + 2'd1;
									state_q <= (is_line_q || (seg_q == 2'd3)) ?
										S_DONE : S_LINIT;
								end else begin
									px_q    <= ln_x;
									py_q    <= ln_y;
									err_q   <= ln_err;
									state_q <= S_EMIT;
								end
							end
							M_CIRC: begin
								oct_q <= oct_q + 3'd1;
								if (oct_q == 3'd7) begin
									cxr_q   <= cn_x;
									cyr_q   <= cn_y;
									cerr_q  <= c_err2;
									state_q <= (cn_x >= cn_y) ? S_EMIT : S_DONE;
								end else begin
									state_q <= S_EMIT;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_DONE: begin
					// hand the result to the output register
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_rd_q    <= rd_res_q;
						out_vis_q   <= visits_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_vis_q, out_rd_q};

	// a pixel request only goes out when the unit can take it
	a_req_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pix_req.valid |-> pix_rsp.ready) else $error("pixel request while unit busy");
	// an issued pixel is always waited for
	a_emit_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |=> (state_q == S_WAIT)) else $error("emit not followed by wait");
	// an in-bounds visit always leaves a nonzero count
	a_visit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT) && pix_rsp.done && pix_rsp.hit |=> (visits_q != '0))
		else $error("visit not counted");

endmodule
